>>> src/line_oriented_box_clipper_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the oriented box line clipper
// Shared helpers for the port checker.
// ----------------------------------------------------------------------------
`ifndef LINE_ORIENTED_BOX_CLIPPER_TOP_ASSERT_SVH
`define LINE_ORIENTED_BOX_CLIPPER_TOP_ASSERT_SVH

// Checked on every clock outside reset.
`define LOBC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked on every clock, reset included.
`define LOBC_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`endif

>>> src/lobc_pkg.sv
// ----------------------------------------------------------------------------
// lobc_pkg
// Types, widths, register codes and saturation helpers of the box clipper.
// ----------------------------------------------------------------------------
package lobc_pkg;

    localparam int CW       = 16;          // coordinate / parameter width, Q8.8
    localparam int LW       = 16;          // register lane width
    localparam int RW       = 3 * LW;      // configuration register width
    localparam int AX_FRAC  = 14;          // axis fraction bits
    localparam int FRAC     = 8;           // coordinate fraction bits
    localparam int REL_W    = CW + 1;      // origin less center
    localparam int PRD_W    = REL_W + LW;  // one projection product
    localparam int SUM_W    = PRD_W + 2;   // three-term dot product
    localparam int NUM_W    = CW + 2;      // slab numerator
    localparam int NN_W     = NUM_W + FRAC;// numerator scaled by one
    localparam int DEN_W    = CW + 1;      // slab denominator
    localparam int MUL_W    = DEN_W + CW;  // denominator times t
    localparam int PT_W     = 2 * CW;      // t times direction
    localparam int SLABS    = 6;
    localparam int DIV_LAT  = CW + 2;      // divider pipeline depth
    localparam int SAT_W    = 40;          // width handed to the clamps

    typedef logic [2:0] t_cfg_idx;
    localparam t_cfg_idx REG_CENTER = 3'd0;
    localparam t_cfg_idx REG_RIGHT  = 3'd1;
    localparam t_cfg_idx REG_UP     = 3'd2;
    localparam t_cfg_idx REG_FWD    = 3'd3;
    localparam t_cfg_idx REG_HALF   = 3'd4;

    localparam logic [RW-1:0] RST_CENTER = 48'h0000_0000_0000;
    localparam logic [RW-1:0] RST_RIGHT  = 48'h0000_0000_4000;
    localparam logic [RW-1:0] RST_UP     = 48'h0000_4000_0000;
    localparam logic [RW-1:0] RST_FWD    = 48'h4000_0000_0000;
    localparam logic [RW-1:0] RST_HALF   = 48'h0100_0100_0100;

    typedef struct packed {
        logic signed [CW-1:0] origin_x;
        logic signed [CW-1:0] origin_y;
        logic signed [CW-1:0] origin_z;
        logic signed [CW-1:0] dir_x;
        logic signed [CW-1:0] dir_y;
        logic signed [CW-1:0] dir_z;
        logic signed [CW-1:0] t_start;
        logic signed [CW-1:0] t_end;
        logic                 solid_box;
    } t_in;

    typedef struct packed {
        logic [1:0]           hit_count;
        logic signed [CW-1:0] entry_x;
        logic signed [CW-1:0] entry_y;
        logic signed [CW-1:0] entry_z;
        logic signed [CW-1:0] exit_x;
        logic signed [CW-1:0] exit_y;
        logic signed [CW-1:0] exit_z;
        logic                 saturated;
    } t_out;

    // Everything one item carries from the slab setup to the point stage.
    typedef struct packed {
        t_in                              item;
        logic [SLABS-1:0][NN_W-1:0]       n;
        logic [SLABS-1:0][DEN_W-1:0]      den;
        logic [SLABS-1:0][CW-1:0]         q;
        logic [SLABS-1:0]                 qs;
        logic signed [CW-1:0]             t0;
        logic signed [CW-1:0]             t1;
        logic                             ok;
        logic                             flag;
        logic signed [MUL_W-1:0]          m0;
        logic signed [MUL_W-1:0]          m1;
    } t_work;

    function automatic logic signed [LW-1:0] lane(input logic [RW-1:0] r, input int k);
        return r[k*LW +: LW];
    endfunction

    function automatic logic signed [CW-1:0] org_of(input t_in it, input int k);
        logic signed [CW-1:0] v;
        case (k)
            0:       v = it.origin_x;
            1:       v = it.origin_y;
            default: v = it.origin_z;
        endcase
        return v;
    endfunction

    function automatic logic signed [CW-1:0] dir_of(input t_in it, input int k);
        logic signed [CW-1:0] v;
        case (k)
            0:       v = it.dir_x;
            1:       v = it.dir_y;
            default: v = it.dir_z;
        endcase
        return v;
    endfunction

    // Sign and magnitude to clamped CW-bit value; MSB of result is the clamp flag.
    function automatic logic [CW:0] sat_mag(input logic neg, input logic [SAT_W-1:0] mag);
        logic [SAT_W-1:0] lim;
        logic [CW-1:0]    v;
        logic             f;
        lim = neg ? (SAT_W'(1) << (CW-1)) : ((SAT_W'(1) << (CW-1)) - SAT_W'(1));
        f   = (mag > lim);
        if (f) begin
            v = neg ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        end else begin
            v = neg ? (~mag[CW-1:0] + 1'b1) : mag[CW-1:0];
        end
        return {f, v};
    endfunction

    // Signed value to clamped CW-bit value; MSB of result is the clamp flag.
    function automatic logic [CW:0] sat_sgn(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        hi = $signed({{(SAT_W-CW+1){1'b0}}, {(CW-1){1'b1}}});
        lo = $signed({{(SAT_W-CW+1){1'b1}}, {(CW-1){1'b0}}});
        if (v > hi) begin
            return {1'b1, hi[CW-1:0]};
        end else if (v < lo) begin
            return {1'b1, lo[CW-1:0]};
        end
        return {1'b0, v[CW-1:0]};
    endfunction

endpackage

>>> src/lobc_div.sv
// ----------------------------------------------------------------------------
// lobc_div
// Six-lane pipelined restoring divider, one quotient bit per stage.
// Rounds to nearest, ties away from zero, and clamps to CW bits.
// ----------------------------------------------------------------------------
module lobc_div (
    input  logic                                                i_clk,
    input  logic                                                i_en,
    input  logic [lobc_pkg::SLABS-1:0][lobc_pkg::NN_W-1:0]      i_num,
    input  logic [lobc_pkg::SLABS-1:0][lobc_pkg::DEN_W-1:0]     i_den,
    output logic [lobc_pkg::SLABS-1:0][lobc_pkg::CW-1:0]        o_quo,
    output logic [lobc_pkg::SLABS-1:0]                          o_sat
);
    import lobc_pkg::*;

    localparam int QB    = CW;
    localparam int R_W   = NN_W + 1;
    localparam int D_W   = DEN_W + 1;
    localparam int CMP_W = D_W + QB + 1;

    typedef struct packed {
        logic [R_W-1:0] rem;
        logic [D_W-1:0] dv;
        logic [QB-1:0]  q;
        logic           neg;
        logic           ovf;
    } t_dstep;

    t_dstep r_st [QB+1][SLABS];
    t_dstep n_st [QB+1][SLABS];
    logic [SLABS-1:0][CW-1:0] n_quo;
    logic [SLABS-1:0]         n_sat;

    always_comb begin
        logic signed [R_W-1:0] nx;
        logic signed [D_W-1:0] dx;
        logic [R_W-1:0]        an;
        logic [D_W-1:0]        ad;
        logic [CMP_W-1:0]      sub;
        logic [CW:0]           rs;
        for (int l = 0; l < SLABS; l++) begin
            // setup: N = 2|n| + |d|, D = 2|d|, so floor(N / D) rounds half away
            nx = R_W'($signed(i_num[l]));
            dx = D_W'($signed(i_den[l]));
            an = nx[R_W-1] ? R_W'(-nx) : R_W'(nx);
            ad = dx[D_W-1] ? D_W'(-dx) : D_W'(dx);
            n_st[0][l].rem = (an << 1) + R_W'(ad);
            n_st[0][l].dv  = ad << 1;
            n_st[0][l].q   = '0;
            n_st[0][l].neg = i_num[l][NN_W-1] ^ i_den[l][DEN_W-1];
            n_st[0][l].ovf = CMP_W'(n_st[0][l].rem) >= (CMP_W'(n_st[0][l].dv) << QB);
            for (int k = 1; k <= QB; k++) begin
                n_st[k][l] = r_st[k-1][l];
                sub = CMP_W'(r_st[k-1][l].dv) << (QB - k);
                if (CMP_W'(r_st[k-1][l].rem) >= sub) begin
                    n_st[k][l].rem       = r_st[k-1][l].rem - R_W'(sub);
                    n_st[k][l].q[QB - k] = 1'b1;
                end
            end
            rs = sat_mag(r_st[QB][l].neg,
                         r_st[QB][l].ovf ? {SAT_W{1'b1}} : SAT_W'(r_st[QB][l].q));
            n_quo[l] = rs[CW-1:0];
            n_sat[l] = rs[CW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st  <= n_st;
            o_quo <= n_quo;
            o_sat <= n_sat;
        end
    end

endmodule

>>> src/line_oriented_box_clipper_top.sv
// ----------------------------------------------------------------------------
// line_oriented_box_clipper_top
// Liang-Barsky clipping of a parametric line against an oriented box.
//
//   channel  direction  handshake                 payload
//   in       input      i_in_valid / o_in_ready   i_in_data  (t_in)
//   out      output     o_out_valid / i_out_ready o_out_data (t_out)
//   cfg      input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One item per cycle sustained while the output queue has room. From acceptance
// to o_out_valid: five front stages, the slab divider (one quotient bit per stage),
// one stage to join the quotients, two per slab clip, two point stages, the queue.
// Synchronous active-low reset clears valids, the output queue and the box
// registers to a unit box at the origin.
// The whole pipeline moves together; it halts only when the two-entry output
// queue is full, so a waiting result does not block new items.
// ----------------------------------------------------------------------------
module line_oriented_box_clipper_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  lobc_pkg::t_in               i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output lobc_pkg::t_out              o_out_data,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  lobc_pkg::t_cfg_idx          i_cfg_index,
    input  logic [lobc_pkg::RW-1:0]     i_cfg_data
);
    import lobc_pkg::*;

    // valid bit positions: 5 front stages, divider, 13 clip stages, 2 point stages
    localparam int NSTG = 5 + DIV_LAT + 2*SLABS + 1 + 2;
    localparam int NCL  = 2*SLABS + 1;

    // ---------------- configuration ----------------
    logic [RW-1:0] r_center, r_right, r_up, r_fwd, r_half;
    logic [RW-1:0] axis [3];

    assign o_cfg_ready = 1'b1;
    assign axis[0] = r_right;
    assign axis[1] = r_up;
    assign axis[2] = r_fwd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center <= RST_CENTER;
            r_right  <= RST_RIGHT;
            r_up     <= RST_UP;
            r_fwd    <= RST_FWD;
            r_half   <= RST_HALF;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_CENTER: r_center <= i_cfg_data;
                REG_RIGHT:  r_right  <= i_cfg_data;
                REG_UP:     r_up     <= i_cfg_data;
                REG_FWD:    r_fwd    <= i_cfg_data;
                REG_HALF:   r_half   <= i_cfg_data;
                default: ;  // unknown index ignored
            endcase
        end
    end

    // ---------------- flow control ----------------
    logic [1:0]      r_cnt;
    logic [NSTG-1:0] r_vld;
    logic            adv;
    logic            push;
    logic            pop;

    assign adv        = (r_cnt != 2'd2);
    assign o_in_ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NSTG-2:0], i_in_valid};
        end
    end

    // ---------------- stage 1: origin less center ----------------
    t_in                   r_s1_item;
    logic signed [REL_W-1:0] r_s1_rel [3];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_item <= i_in_data;
            for (int k = 0; k < 3; k++) begin
                r_s1_rel[k] <= REL_W'(org_of(i_in_data, k)) - REL_W'(lane(r_center, k));
            end
        end
    end

    // ---------------- stage 2: projection products ----------------
    t_in                     r_s2_item;
    logic signed [PRD_W-1:0] r_s2_pr [3][3];
    logic signed [PRD_W-1:0] r_s2_pd [3][3];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2_item <= r_s1_item;
            for (int a = 0; a < 3; a++) begin
                for (int k = 0; k < 3; k++) begin
                    r_s2_pr[a][k] <= PRD_W'(r_s1_rel[k]) * PRD_W'(lane(axis[a], k));
                    r_s2_pd[a][k] <= PRD_W'(dir_of(r_s1_item, k)) * PRD_W'(lane(axis[a], k));
                end
            end
        end
    end

    // ---------------- stage 3: dot products ----------------
    t_in                     r_s3_item;
    logic signed [SUM_W-1:0] r_s3_sp [3];
    logic signed [SUM_W-1:0] r_s3_sd [3];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s3_item <= r_s2_item;
            for (int a = 0; a < 3; a++) begin
                r_s3_sp[a] <= SUM_W'(r_s2_pr[a][0]) + SUM_W'(r_s2_pr[a][1])
                            + SUM_W'(r_s2_pr[a][2]);
                r_s3_sd[a] <= SUM_W'(r_s2_pd[a][0]) + SUM_W'(r_s2_pd[a][1])
                            + SUM_W'(r_s2_pd[a][2]);
            end
        end
    end

    // ---------------- stage 4: round Q.22 to Q8.8 and clamp ----------------
    t_in                  r_s4_item;
    logic [CW-1:0]        r_s4_p [3];
    logic [CW-1:0]        r_s4_d [3];
    logic                 r_s4_flag;
    logic [CW-1:0]        n_s4_p [3];
    logic [CW-1:0]        n_s4_d [3];
    logic                 n_s4_flag;

    always_comb begin
        logic [SUM_W-1:0] mag;
        logic [SUM_W-1:0] rnd;
        logic [CW:0]      rs;
        n_s4_flag = 1'b0;
        for (int a = 0; a < 3; a++) begin
            mag = r_s3_sp[a][SUM_W-1] ? SUM_W'(-r_s3_sp[a]) : SUM_W'(r_s3_sp[a]);
            rnd = (mag + (SUM_W'(1) << (AX_FRAC-1))) >> AX_FRAC;
            rs  = sat_mag(r_s3_sp[a][SUM_W-1], SAT_W'(rnd));
            n_s4_p[a] = rs[CW-1:0];
            n_s4_flag = n_s4_flag | rs[CW];
            mag = r_s3_sd[a][SUM_W-1] ? SUM_W'(-r_s3_sd[a]) : SUM_W'(r_s3_sd[a]);
            rnd = (mag + (SUM_W'(1) << (AX_FRAC-1))) >> AX_FRAC;
            rs  = sat_mag(r_s3_sd[a][SUM_W-1], SAT_W'(rnd));
            n_s4_d[a] = rs[CW-1:0];
            n_s4_flag = n_s4_flag | rs[CW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s4_item <= r_s3_item;
            r_s4_p    <= n_s4_p;
            r_s4_d    <= n_s4_d;
            r_s4_flag <= n_s4_flag;
        end
    end

    // ---------------- stage 5: slab numerators and denominators ----------------
    // slab 2a tests the -axis face (den = d), slab 2a+1 the +axis face (den = -d)
    t_work r_w5;
    t_work n_w5;

    always_comb begin
        logic signed [NUM_W-1:0] p;
        logic signed [NUM_W-1:0] e;
        logic signed [NUM_W-1:0] num;
        n_w5      = '0;
        n_w5.item = r_s4_item;
        n_w5.t0   = r_s4_item.t_start;
        n_w5.t1   = r_s4_item.t_end;
        n_w5.ok   = 1'b1;
        n_w5.flag = r_s4_flag;
        for (int a = 0; a < 3; a++) begin
            p   = NUM_W'($signed(r_s4_p[a]));
            e   = NUM_W'(lane(r_half, a));
            num = -p - e;
            n_w5.n[2*a]     = {num, {FRAC{1'b0}}};
            n_w5.den[2*a]   = DEN_W'($signed(r_s4_d[a]));
            num = p - e;
            n_w5.n[2*a+1]   = {num, {FRAC{1'b0}}};
            n_w5.den[2*a+1] = DEN_W'(0) - DEN_W'($signed(r_s4_d[a]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_w5 <= n_w5;
        end
    end

    // ---------------- slab quotients, in parallel with a delay line ----------------
    logic [SLABS-1:0][CW-1:0] div_q;
    logic [SLABS-1:0]         div_s;
    t_work                    r_dl [DIV_LAT];

    lobc_div u_div (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_num (r_w5.n),
        .i_den (r_w5.den),
        .o_quo (div_q),
        .o_sat (div_s)
    );

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dl[0] <= r_w5;
            for (int i = 1; i < DIV_LAT; i++) begin
                r_dl[i] <= r_dl[i-1];
            end
        end
    end

    // ---------------- six slab clips, two stages each ----------------
    // even stage: den * t0, den * t1; odd stage: compare and narrow.
    t_work r_c [NCL];
    t_work n_c [NCL];

    always_comb begin
        logic signed [NN_W-1:0]  nn;
        logic signed [DEN_W-1:0] dd;
        logic signed [MUL_W-1:0] nx;
        n_c[0]    = r_dl[DIV_LAT-1];
        n_c[0].q  = div_q;
        n_c[0].qs = div_s;
        for (int j = 0; j < SLABS; j++) begin
            n_c[2*j+1]    = r_c[2*j];
            dd            = $signed(r_c[2*j].den[j]);
            n_c[2*j+1].m0 = MUL_W'(dd) * MUL_W'(r_c[2*j].t0);
            n_c[2*j+1].m1 = MUL_W'(dd) * MUL_W'(r_c[2*j].t1);

            n_c[2*j+2] = r_c[2*j+1];
            nn = $signed(r_c[2*j+1].n[j]);
            dd = $signed(r_c[2*j+1].den[j]);
            nx = MUL_W'(nn);
            if (r_c[2*j+1].ok) begin
                if (!dd[DEN_W-1] && (dd != '0)) begin
                    // entering face
                    if (nx > r_c[2*j+1].m1) begin
                        n_c[2*j+2].ok = 1'b0;
                    end else if (nx > r_c[2*j+1].m0) begin
                        n_c[2*j+2].t0   = $signed(r_c[2*j+1].q[j]);
                        n_c[2*j+2].flag = r_c[2*j+1].flag | r_c[2*j+1].qs[j];
                    end
                end else if (dd == '0) begin
                    // parallel to the face: inside only if numerator <= 0
                    n_c[2*j+2].ok = nn[NN_W-1] || (nn == '0);
                end else begin
                    // leaving face
                    if (nx > r_c[2*j+1].m0) begin
                        n_c[2*j+2].ok = 1'b0;
                    end else if (nx > r_c[2*j+1].m1) begin
                        n_c[2*j+2].t1   = $signed(r_c[2*j+1].q[j]);
                        n_c[2*j+2].flag = r_c[2*j+1].flag | r_c[2*j+1].qs[j];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c <= n_c;
        end
    end

    // ---------------- point stage 1: decision and t * dir ----------------
    t_in                    r_p1_item;
    logic                   r_p1_rep;
    logic                   r_p1_two;
    logic                   r_p1_flag;
    logic signed [PT_W-1:0] r_p1_m0 [3];
    logic signed [PT_W-1:0] r_p1_m1 [3];
    t_work                  cl_out;

    assign cl_out = r_c[NCL-1];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p1_item <= cl_out.item;
            r_p1_rep  <= cl_out.ok && (cl_out.item.solid_box
                         || (cl_out.t0 != cl_out.item.t_start)
                         || (cl_out.t1 != cl_out.item.t_end));
            r_p1_two  <= (cl_out.t1 > cl_out.t0);
            r_p1_flag <= cl_out.flag;
            for (int k = 0; k < 3; k++) begin
                r_p1_m0[k] <= PT_W'(cl_out.t0) * PT_W'(dir_of(cl_out.item, k));
                r_p1_m1[k] <= PT_W'(cl_out.t1) * PT_W'(dir_of(cl_out.item, k));
            end
        end
    end

    // ---------------- point stage 2: round, add origin, clamp ----------------
    function automatic logic [CW:0] pt_calc(input logic signed [PT_W-1:0] prod,
                                            input logic signed [CW-1:0]   org);
        logic [PT_W-1:0]         mag;
        logic [PT_W-1:0]         rnd;
        logic signed [SAT_W-1:0] sv;
        mag = prod[PT_W-1] ? PT_W'(-prod) : PT_W'(prod);
        rnd = (mag + (PT_W'(1) << (FRAC-1))) >> FRAC;
        sv  = prod[PT_W-1] ? (SAT_W'(0) - SAT_W'(rnd)) : SAT_W'(rnd);
        return sat_sgn(SAT_W'(org) + sv);
    endfunction

    t_out r_p2;
    t_out n_p2;

    always_comb begin
        logic [CW:0] a0 [3];
        logic [CW:0] a1 [3];
        logic        f;
        for (int k = 0; k < 3; k++) begin
            a0[k] = pt_calc(r_p1_m0[k], org_of(r_p1_item, k));
            a1[k] = pt_calc(r_p1_m1[k], org_of(r_p1_item, k));
        end
        f    = r_p1_flag;
        n_p2 = '0;
        if (r_p1_rep) begin
            n_p2.hit_count = r_p1_two ? 2'd2 : 2'd1;
            n_p2.entry_x   = a0[0][CW-1:0];
            n_p2.entry_y   = a0[1][CW-1:0];
            n_p2.entry_z   = a0[2][CW-1:0];
            f = f | a0[0][CW] | a0[1][CW] | a0[2][CW];
            if (r_p1_two) begin
                n_p2.exit_x = a1[0][CW-1:0];
                n_p2.exit_y = a1[1][CW-1:0];
                n_p2.exit_z = a1[2][CW-1:0];
                f = f | a1[0][CW] | a1[1][CW] | a1[2][CW];
            end
        end
        n_p2.saturated = f;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p2 <= n_p2;
        end
    end

    // ---------------- two-entry output queue ----------------
    t_out r_q0;
    t_out r_q1;

    assign push        = adv && r_vld[NSTG-1];
    assign pop         = (r_cnt != 2'd0) && i_out_ready;
    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_data  = r_q0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_q0 <= (r_cnt == 2'd2) ? r_q1 : r_p2;
        end else if (push) begin
            if (r_cnt == 2'd0) begin
                r_q0 <= r_p2;
            end else begin
                r_q1 <= r_p2;
            end
        end
    end

endmodule

>>> src/lobc_chk.sv
// ----------------------------------------------------------------------------
// lobc_chk
// Port-level checker for the box clipper, bound to the top level.
// ----------------------------------------------------------------------------
`include "line_oriented_box_clipper_top_assert.svh"

module lobc_chk (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     o_in_ready,
    input logic                     o_out_valid,
    input logic                     i_out_ready,
    input lobc_pkg::t_out           o_out_data
);
    import lobc_pkg::*;

    logic       stall;
    logic [1:0] hc;
    logic       entry_zero;
    logic       exit_zero;

    assign stall      = o_out_valid && !i_out_ready;
    assign hc         = o_out_data.hit_count;
    assign entry_zero = (o_out_data.entry_x == '0) && (o_out_data.entry_y == '0)
                        && (o_out_data.entry_z == '0);
    assign exit_zero  = (o_out_data.exit_x == '0) && (o_out_data.exit_y == '0)
                        && (o_out_data.exit_z == '0);

    // stalled result holds
    `LOBC_ASSERT(a_out_hold, stall |=> o_out_valid && $stable(o_out_data), "stalled item changed")

    // no point means all coordinates zero
    `LOBC_ASSERT(a_zero_none, o_out_valid && hc == 2'd0 |-> entry_zero && exit_zero, "coords without hit")

    // exit point only with two hits, count never three
    `LOBC_ASSERT(a_exit_two, o_out_valid && hc != 2'd2 |-> hc != 2'd3 && exit_zero, "bad exit point")

    // reset empties the output and opens the input
    `LOBC_ASSERT_RST(a_reset, !i_rst_n |=> !o_out_valid && o_in_ready, "reset left the block busy")

endmodule

bind line_oriented_box_clipper_top lobc_chk u_lobc_chk (.*);

>>> bench/line_oriented_box_clipper_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_oriented_box_clipper_top_tb
// Self-checking bench for the box clipper. A bit-exact clip predictor runs
// beside the block. Stimulus covers corner rays and then random rays through
// several box setups. Both handshakes idle at random, and the receiver holds
// off once for a long stretch so that the pipeline fills.
// ----------------------------------------------------------------------------
module line_oriented_box_clipper_top_tb;
    import lobc_pkg::*;

    localparam int LAT = 38;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_in_valid = 1'b0;
    logic           o_in_ready;
    t_in            i_in_data = '0;
    logic           o_out_valid;
    logic           i_out_ready = 1'b0;
    t_out           o_out_data;
    logic           i_cfg_valid = 1'b0;
    logic           o_cfg_ready;
    t_cfg_idx       i_cfg_index = REG_CENTER;
    logic [RW-1:0]  i_cfg_data = '0;

    line_oriented_box_clipper_top u_top (.*);

    always #1 i_clk = ~i_clk;

    // Box setup as the predictor sees it.
    logic [RW-1:0] box_ctr, box_rt, box_up, box_fw, box_half;

    t_in  ray_q[$];      // rays waiting for the driver
    t_out hits_q[$];     // predicted clip results, oldest first
    int   n_err = 0;
    bit   calm = 1'b0;    // no idling while set
    bit   hold_go = 1'b0; // asks for the long receiver hold-off
    bit   hold_rx = 1'b0; // receiver hold-off in progress
    logic o_in_ready_q = 1'b0;  // ready as sampled at the rising edge

    // ---------------- predictor ----------------
    function automatic longint sx16(input logic [15:0] v);
        return longint'($signed(v));
    endfunction

    function automatic longint lane_of(input logic [RW-1:0] r, input int k);
        return sx16(r[k*16 +: 16]);
    endfunction

    // nearest, ties away from zero
    function automatic longint div_rnd(input longint n, input longint d);
        longint an, ad, q;
        an = (n < 0) ? -n : n;
        ad = (d < 0) ? -d : d;
        q = (2 * an + ad) / (2 * ad);
        return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    function automatic longint clamp16(input longint v, inout bit f);
        if (v > 32767) begin
            f = 1'b1;
            return 32767;
        end
        if (v < -32768) begin
            f = 1'b1;
            return -32768;
        end
        return v;
    endfunction

    function automatic longint proj(input longint v[3], input logic [RW-1:0] ax, inout bit f);
        longint s;
        s = v[0] * lane_of(ax, 0) + v[1] * lane_of(ax, 1) + v[2] * lane_of(ax, 2);
        return clamp16(div_rnd(s, 64'sd1 << AX_FRAC), f);
    endfunction

    function automatic bit slab(input longint den, input longint num,
                                inout longint t0, inout longint t1, inout bit f);
        longint n;
        n = num * 256;
        if (den > 0) begin
            if (n > den * t1) return 1'b0;
            if (n > den * t0) t0 = clamp16(div_rnd(n, den), f);
            return 1'b1;
        end
        if (den == 0) return num <= 0;
        if (n > den * t0) return 1'b0;
        if (n > den * t1) t1 = clamp16(div_rnd(n, den), f);
        return 1'b1;
    endfunction

    function automatic t_out clip_ray(input t_in r);
        longint org[3], dr[3], rel[3], p[3], d[3], e[3], p0[3], p1[3];
        longint t0, t1;
        logic [RW-1:0] ax[3];
        bit f, ok;
        int hits;
        t_out o;
        f = 1'b0;
        ok = 1'b1;
        hits = 0;
        ax[0] = box_rt; ax[1] = box_up; ax[2] = box_fw;
        org[0] = r.origin_x; org[1] = r.origin_y; org[2] = r.origin_z;
        dr[0] = r.dir_x; dr[1] = r.dir_y; dr[2] = r.dir_z;
        for (int i = 0; i < 3; i++) begin
            rel[i] = org[i] - lane_of(box_ctr, i);
            e[i] = lane_of(box_half, i);
            p0[i] = 0;
            p1[i] = 0;
        end
        for (int i = 0; i < 3; i++) begin
            p[i] = proj(rel, ax[i], f);
            d[i] = proj(dr, ax[i], f);
        end
        t0 = r.t_start;
        t1 = r.t_end;
        for (int i = 0; i < 3 && ok; i++) begin
            ok = slab(d[i], -p[i] - e[i], t0, t1, f);
            if (ok) ok = slab(-d[i], p[i] - e[i], t0, t1, f);
        end
        if (ok && (r.solid_box || t0 != longint'(r.t_start) || t1 != longint'(r.t_end))) begin
            hits = (t1 > t0) ? 2 : 1;
            for (int i = 0; i < 3; i++) begin
                p0[i] = clamp16(org[i] + div_rnd(t0 * dr[i], 256), f);
                if (hits == 2) p1[i] = clamp16(org[i] + div_rnd(t1 * dr[i], 256), f);
            end
        end
        o.hit_count = 2'(hits);
        o.entry_x = p0[0][15:0]; o.entry_y = p0[1][15:0]; o.entry_z = p0[2][15:0];
        o.exit_x = p1[0][15:0]; o.exit_y = p1[1][15:0]; o.exit_z = p1[2][15:0];
        o.saturated = f;
        return o;
    endfunction

    // ---------------- driver ----------------
    // Prediction happens at acceptance so it uses the box of the moment.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready_q) begin
                // accepted at the last rising edge
            end
            if (!i_in_valid || o_in_ready_q) begin
                if (ray_q.size() > 0 && (calm || $urandom_range(99) >= 24)) begin
                    i_in_data <= ray_q.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_ready <= !hold_rx && (calm || $urandom_range(99) >= 24);
        end
    end

    always @(posedge i_clk) begin
        o_in_ready_q <= o_in_ready;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            hits_q.push_back(clip_ray(i_in_data));
        end
    end

    // Long receiver hold-off, counted here while the sender keeps offering.
    initial begin
        wait (hold_go);
        hold_rx = 1'b1;
        repeat (300) @(posedge i_clk);
        hold_rx = 1'b0;
    end

    // ---------------- monitor ----------------
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (hits_q.size() == 0) begin
                n_err <= n_err + 1;
                if (n_err < 10) $display("unexpected result %h", o_out_data);
            end else begin
                want = hits_q.pop_front();
                if (want.hit_count !== o_out_data.hit_count ||
                    want.entry_x !== o_out_data.entry_x ||
                    want.entry_y !== o_out_data.entry_y ||
                    want.entry_z !== o_out_data.entry_z ||
                    want.exit_x !== o_out_data.exit_x ||
                    want.exit_y !== o_out_data.exit_y ||
                    want.exit_z !== o_out_data.exit_z ||
                    want.saturated !== o_out_data.saturated) begin
                    n_err <= n_err + 1;
                    if (n_err < 10)
                        $display("mismatch: expected %h got %h", want, o_out_data);
                end
            end
        end
    end

    // ---------------- stimulus helpers ----------------
    task automatic write_box(input t_cfg_idx idx, input logic [RW-1:0] val);
        @(negedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data <= val;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_CENTER: box_ctr = val;
            REG_RIGHT:  box_rt = val;
            REG_UP:     box_up = val;
            REG_FWD:    box_fw = val;
            REG_HALF:   box_half = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Wait until every ray is out, then let the pipeline drain.
    task automatic drain();
        while (ray_q.size() > 0 || i_in_valid || hits_q.size() > 0) @(posedge i_clk);
        repeat (LAT + 10) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rnd16();
        case ($urandom_range(5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($urandom);
            default: return 16'($signed($urandom_range(2047)) - 1024);
        endcase
    endfunction

    // Mostly rays aimed at the box with sensible spans, some raw noise.
    function automatic t_in make_ray();
        t_in r;
        r = '0;
        if ($urandom_range(9) < 2) begin
            r = t_in'(($bits(t_in))'({$urandom, $urandom, $urandom, $urandom, $urandom}));
        end else begin
            r.origin_x = 16'($signed(lane_of(box_ctr, 0)) + $signed($urandom_range(1535)) - 768);
            r.origin_y = 16'($signed(lane_of(box_ctr, 1)) + $signed($urandom_range(1535)) - 768);
            r.origin_z = 16'($signed(lane_of(box_ctr, 2)) + $signed($urandom_range(1535)) - 768);
            r.dir_x = ($urandom_range(7) == 0) ? rnd16() : 16'($signed($urandom_range(1023)) - 512);
            r.dir_y = ($urandom_range(7) == 0) ? rnd16() : 16'($signed($urandom_range(1023)) - 512);
            r.dir_z = ($urandom_range(5) == 0) ? 16'h0 : 16'($signed($urandom_range(1023)) - 512);
            r.t_start = ($urandom_range(7) == 0) ? rnd16() : 16'($signed($urandom_range(767)) - 512);
            r.t_end = ($urandom_range(7) == 0) ? rnd16() : 16'($signed($urandom_range(1279)) - 256);
            r.solid_box = 1'($urandom_range(1));
        end
        return r;
    endfunction

    function automatic t_in ray_of(input logic [15:0] ox, oy, oz, dx, dy, dz, ts, te,
                                   input logic s);
        t_in r;
        r.origin_x = ox; r.origin_y = oy; r.origin_z = oz;
        r.dir_x = dx; r.dir_y = dy; r.dir_z = dz;
        r.t_start = ts; r.t_end = te; r.solid_box = s;
        return r;
    endfunction

    // ---------------- main sequence ----------------
    initial begin
        box_ctr = RST_CENTER; box_rt = RST_RIGHT; box_up = RST_UP;
        box_fw = RST_FWD; box_half = RST_HALF;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: crossing, inside-solid, inside-hollow, miss, zero
        // denominator, reversed span, extremes.
        ray_q.push_back(ray_of(16'hFE00, 0, 0, 16'h0100, 0, 0, 0, 16'h0400, 0));
        ray_q.push_back(ray_of(0, 0, 0, 16'h0010, 0, 0, 0, 16'h0100, 1));
        ray_q.push_back(ray_of(0, 0, 0, 16'h0010, 0, 0, 0, 16'h0100, 0));
        ray_q.push_back(ray_of(16'h0400, 16'h0400, 0, 0, 0, 16'h0100, 0, 16'h0100, 1));
        ray_q.push_back(ray_of(0, 0, 0, 0, 0, 0, 0, 16'h0100, 1));
        ray_q.push_back(ray_of(0, 16'h0200, 0, 16'h0100, 0, 0, 0, 16'h0100, 1));
        ray_q.push_back(ray_of(16'hFE00, 0, 0, 16'h0100, 0, 0, 16'h0400, 0, 1));
        ray_q.push_back(ray_of(16'hFE00, 0, 0, 16'h0100, 0, 0, 16'h0200, 16'h0200, 0));
        ray_q.push_back(ray_of(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                               16'h8000, 16'h7FFF, 1));
        ray_q.push_back(ray_of(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                               16'h8000, 16'h7FFF, 0));
        ray_q.push_back(ray_of(16'h8000, 0, 0, 16'h7FFF, 0, 0, 16'h8000, 16'h7FFF, 1));
        ray_q.push_back(ray_of(0, 16'hFF00, 16'h0080, 16'h0003, 16'h0007, 16'hFFFB,
                               16'h8000, 16'h7FFF, 0));
        ray_q.push_back(ray_of(16'h0100, 0, 0, 16'hFF00, 16'h0001, 0, 0, 16'h0200, 0));
        ray_q.push_back(ray_of(16'hFF00, 16'hFF00, 16'hFF00, 16'h0080, 16'h0080, 16'h0080,
                               0, 16'h0400, 0));
        drain();

        // Random phases over box setups, the extremes among them.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: ;
                1: begin
                    write_box(REG_CENTER, {16'h0080, 16'hFF80, 16'h0100});
                    write_box(REG_HALF, {16'h0200, 16'h0080, 16'h0180});
                end
                2: begin  // rotated 45 degrees about z
                    write_box(REG_RIGHT, {16'h0000, 16'h2D41, 16'h2D41});
                    write_box(REG_UP, {16'h0000, 16'h2D41, 16'hD2BF});
                end
                3: begin  // degenerate: all-ones and maximal lanes
                    write_box(REG_FWD, 48'hFFFF_FFFF_FFFF);
                    write_box(REG_HALF, 48'h7FFF_0000_8000);
                    write_box(REG_CENTER, 48'h8000_7FFF_8000);
                end
                4: begin
                    write_box(REG_RIGHT, 48'h7FFF_7FFF_7FFF);
                    write_box(REG_UP, 48'h8000_8000_8000);
                    write_box(REG_FWD, 48'h0);
                    write_box(REG_CENTER, 48'h0);
                end
                5: begin
                    write_box(REG_RIGHT, RW'({$urandom, $urandom}));
                    write_box(REG_HALF, RW'({$urandom, $urandom}));
                end
                6: begin  // back to plain unit axes, half extent three, hollow and solid
                    write_box(REG_CENTER, RST_CENTER);
                    write_box(REG_RIGHT, RST_RIGHT);
                    write_box(REG_UP, RST_UP);
                    write_box(REG_FWD, RST_FWD);
                    write_box(REG_HALF, 48'h0300_0300_0300);
                end
                default: write_box(REG_HALF, 48'h0);
            endcase
            calm = (ph == 2);
            for (int k = 0; k < 225; k++) ray_q.push_back(make_ray());
            if (ph == 4) begin
                // long receiver hold-off while the sender keeps offering
                calm = 1'b1;
                hold_go = 1'b1;
                wait (hold_rx);
                wait (!hold_rx);
                calm = 1'b0;
            end
            drain();
        end

        if (n_err == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule

>>> line_oriented_box_clipper_top.f
+incdir+src
src/lobc_pkg.sv
src/lobc_div.sv
src/line_oriented_box_clipper_top.sv
src/lobc_chk.sv
bench/line_oriented_box_clipper_top_tb.sv
